// File: sv/p3gsd_pkg.sv
`timescale 1ns / 1ps
package p3gsd_pkg;

	localparam int BLOCK_BYTES = 98;
	localparam int SCALE_BYTES = 2;
	localparam int MAX_CODES   = 3;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [31:0]      base;
		logic [1:0]       n;
		logic [2:0][2:0]  code;
		logic [2:0][3:0]  scale;
	} q_entry_t;

	typedef struct packed {
		logic     wr;
		q_entry_t entry;
	} q_write_t;

endpackage

// File: sv/p3gsd_front.sv
`timescale 1ns / 1ps
module p3gsd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               tensor_start,
	input  logic [31:0]        element_count,
	output p3gsd_pkg::q_write_t q_wr
);
	import p3gsd_pkg::*;

	logic [6:0]       bib_q;
	logic [3:0][3:0]  scales_q;
	logic [1:0]       carry_bits_q;
	logic [1:0]       carry_count_q;
	logic [31:0]      emitted_q;

	logic [6:0]       bib_e, bib_w, bib_nx;
	logic [3:0][3:0]  scales_e, scales_nx;
	logic [1:0]       cb_e, cc_e;
	logic [31:0]      emitted_e, remaining;
	logic             ignore, is_quant;
	logic [9:0]       bits, bits_after;
	logic [3:0]       avail, avail_after, shamt;
	logic [1:0]       navail, n;
	logic [7:0]       idx_lo;

	always_comb begin
		bib_e     = tensor_start ? '0 : bib_q;
		scales_e  = tensor_start ? '0 : scales_q;
		cb_e      = tensor_start ? '0 : carry_bits_q;
		cc_e      = tensor_start ? '0 : carry_count_q;
		emitted_e = tensor_start ? '0 : emitted_q;
		ignore    = emitted_e >= element_count;
		bib_w     = (bib_e >= 7'(BLOCK_BYTES)) ? '0 : bib_e;
		if (bib_w == '0) begin
			cb_e = '0;
			cc_e = '0;
		end
		is_quant  = bib_w >= 7'(SCALE_BYTES);
		bib_nx    = (bib_w + 7'd1 >= 7'(BLOCK_BYTES)) ? '0 : bib_w + 7'd1;
		scales_nx = scales_e;
		if (!is_quant) begin
			scales_nx[{bib_w[0], 1'b0}] = data_byte[3:0];
			scales_nx[{bib_w[0], 1'b1}] = data_byte[7:4];
		end
		bits      = ({2'b00, data_byte} << cc_e) | {8'b0, cb_e};
		avail     = 4'd8 + {2'b00, cc_e};
		navail    = (avail >= 4'd9) ? 2'd3 : 2'd2;
		remaining = element_count - emitted_e;
		n         = (remaining < {30'b0, navail}) ? remaining[1:0] : navail;
		shamt     = {2'b00, n} + {1'b0, n, 1'b0};
		bits_after  = bits >> shamt;
		avail_after = avail - shamt;

		q_wr.wr          = accept && !ignore && is_quant;
		q_wr.entry.base  = emitted_e;
		q_wr.entry.n     = n;
		for (int k = 0; k < MAX_CODES; k++) begin
			idx_lo              = emitted_e[7:0] + 8'(k);
			q_wr.entry.code[k]  = bits[3*k +: 3];
			q_wr.entry.scale[k] = scales_e[idx_lo[7:6]];
		end
		idx_lo = emitted_e[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bib_q         <= '0;
			scales_q      <= '0;
			carry_bits_q  <= '0;
			carry_count_q <= '0;
			emitted_q     <= '0;
		end else if (accept) begin
			if (ignore) begin
				if (tensor_start) begin
					bib_q         <= '0;
					scales_q      <= '0;
					carry_bits_q  <= '0;
					carry_count_q <= '0;
					emitted_q     <= '0;
				end
			end else begin
				bib_q    <= bib_nx;
				scales_q <= scales_nx;
				if (is_quant) begin
					emitted_q     <= emitted_e + {30'b0, n};
					carry_bits_q  <= bits_after[1:0];
					carry_count_q <= (avail_after < 4'd3) ? avail_after[1:0] : 2'd0;
				end else begin
					emitted_q     <= emitted_e;
					carry_bits_q  <= cb_e;
					carry_count_q <= cc_e;
				end
			end
		end
	end

endmodule

// File: sv/p3gsd_queue.sv
`timescale 1ns / 1ps
module p3gsd_queue #(
	parameter int DEPTH = p3gsd_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  p3gsd_pkg::q_write_t q_wr,
	input  logic                rd,
	output p3gsd_pkg::q_entry_t head,
	output logic                full,
	output logic                empty
);
	import p3gsd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr, do_rd;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = q_wr.wr && !full;
	assign do_rd = rd && !empty;
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= q_wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: sv/p3gsd_back.sv
`timescale 1ns / 1ps
module p3gsd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  p3gsd_pkg::q_entry_t head,
	input  logic                q_empty,
	output logic                q_rd,
	input  logic [31:0]         element_count,
	output logic                empty,
	input  logic                pop,
	output logic [31:0]         weight_bits,
	output logic [31:0]         weight_index,
	output logic                last_of_run,
	output logic                last_of_tensor
);
	import p3gsd_pkg::*;

	function automatic logic [31:0] to_f32(input logic [2:0] c, input logic [3:0] s);
		logic        neg;
		logic [2:0]  m;
		logic [6:0]  mag;
		logic [2:0]  p;
		logic [29:0] sh;
		logic [31:0] r;
		neg = ~c[2];
		m   = {neg ? ~c[1:0] : c[1:0], 1'b1};
		mag = {4'b0, m} * {3'b0, s};
		p   = '0;
		for (int i = 1; i < 7; i++) begin
			if (mag[i]) p = 3'(i);
		end
		sh = {23'b0, mag} << (5'd23 - {2'b00, p});
		r  = {neg, 8'({5'b0, p} + 8'd122), sh[22:0]};
		if (mag == '0) r = {neg, 31'b0};
		return r;
	endfunction

	logic        out_valid_q;
	logic [1:0]  k_q;
	logic        load, last_k;
	logic [31:0] idx, idx_p1;

	assign load   = !q_empty && (!out_valid_q || pop);
	assign last_k = k_q == head.n - 2'd1;
	assign idx    = head.base + {30'b0, k_q};
	assign idx_p1 = head.base + {30'b0, k_q} + 32'd1;
	assign q_rd   = load && last_k;
	assign empty  = !out_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			weight_bits    <= to_f32(head.code[k_q], head.scale[k_q]);
			weight_index   <= idx;
			last_of_run    <= last_k;
			last_of_tensor <= idx_p1 == element_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				k_q         <= last_k ? '0 : k_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/packed_3bit_group_scale_dequant_core.sv
// accepted code bytes enter the code queue, then their weights are registered at the output
// throughput: one byte per cycle while the code queue has room;
// one weight per cycle out while pop is held; a code byte yields two or three weights,
// fewer at the end of the count; scale bytes and bytes past the element count produce none
// reset: arst_n clears counters, scales, queue and output valid; element_count resets to 0
`timescale 1ns / 1ps
module packed_3bit_group_scale_dequant_core #(
	parameter int QUEUE_DEPTH = p3gsd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        tensor_start,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] weight_bits,
	output logic [31:0] weight_index,
	output logic        last_of_run,
	output logic        last_of_tensor
);
	import p3gsd_pkg::*;

	logic [31:0] element_count_q;
	q_write_t    q_wr;
	q_entry_t    head;
	logic        q_full, q_empty, q_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= '0;
		end else if (cfg_we) begin
			element_count_q <= cfg_wdata;
		end
	end

	assign full = q_full;

	p3gsd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (push && !q_full),
		.data_byte     (data_byte),
		.tensor_start  (tensor_start),
		.element_count (element_count_q),
		.q_wr          (q_wr)
	);

	p3gsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.rd     (q_rd),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	p3gsd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_empty        (q_empty),
		.q_rd           (q_rd),
		.element_count  (element_count_q),
		.empty          (empty),
		.pop            (pop),
		.weight_bits    (weight_bits),
		.weight_index   (weight_index),
		.last_of_run    (last_of_run),
		.last_of_tensor (last_of_tensor)
	);

endmodule

// File: tb/packed_3bit_group_scale_dequant_core_tb.sv
`timescale 1ns / 1ps
module packed_3bit_group_scale_dequant_core_tb;

	localparam int ITEM_TARGET = 470;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 8;

	typedef struct packed {
		logic [31:0] bits;
		logic [31:0] idx;
		logic        run_end;
		logic        tensor_end;
	} weight_t;

	typedef struct packed {
		logic             typed;
		logic [1:0]       nres;
		logic [2:0][31:0] w;
		logic [31:0]      idx0;
		logic             lot;
	} plan_t;

	typedef enum logic [1:0] {ROW_BYTE, ROW_COUNT} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] val;
		logic        ts;
		plan_t       plan;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        tensor_start;
	logic        empty;
	logic        pop;
	logic [31:0] weight_bits;
	logic [31:0] weight_index;
	logic        last_of_run;
	logic        last_of_tensor;

	packed_3bit_group_scale_dequant_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.tensor_start   (tensor_start),
		.empty          (empty),
		.pop            (pop),
		.weight_bits    (weight_bits),
		.weight_index   (weight_index),
		.last_of_run    (last_of_run),
		.last_of_tensor (last_of_tensor)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// dequantizer shadow state
	logic [6:0]  blk_pos    = '0;
	logic [3:0]  scl [4]    = '{default: '0};
	logic [1:0]  cbits      = '0;
	logic [1:0]  ccnt       = '0;
	logic [31:0] emitted    = '0;
	logic [31:0] elem_count = '0;

	weight_t pending_weights [$];
	weight_t fresh [$];
	plan_t   plan_q [$];
	plan_t   loose = '0;
	row_t    script [$];

	int errors          = 0;
	int items_accepted  = 0;
	int useful_items    = 0;
	int weights_checked = 0;
	int counts_written  = 0;
	int tensor_starts   = 0;
	int cycle_count     = 0;
	bit calm            = 1'b0;

	function automatic logic [31:0] weight_float_bits(input logic [2:0] code,
		input logic [3:0] scale);
		logic        neg;
		logic [6:0]  mag;
		logic [7:0]  expo;
		logic [23:0] frac;
		int          msb;
		neg = ~code[2];
		mag = (neg ? (4'd7 - {code, 1'b0}) : ({code, 1'b0} - 4'd7)) * scale;
		if (mag == 0)
			return {neg, 31'b0};
		msb = 0;
		for (int i = 0; i < 7; i++)
			if (mag[i])
				msb = i;
		expo = 8'(msb + 122);
		frac = {17'b0, mag} << (23 - msb);
		return {neg, expo, frac[22:0]};
	endfunction

	task automatic dequant_byte(input logic [7:0] d, input logic ts, output bit active);
		logic [9:0] acc;
		int         avail;
		int         n;
		weight_t    w [3];
		fresh.delete();
		if (ts) begin
			blk_pos = '0;
			scl     = '{default: '0};
			cbits   = '0;
			ccnt    = '0;
			emitted = '0;
		end
		active = (emitted < elem_count);
		if (active) begin
			if (blk_pos == 0) begin
				cbits = '0;
				ccnt  = '0;
			end
			n = 0;
			if (blk_pos < p3gsd_pkg::SCALE_BYTES) begin
				scl[2 * blk_pos]     = d[3:0];
				scl[2 * blk_pos + 1] = d[7:4];
			end else begin
				acc   = {8'b0, cbits} | ({2'b0, d} << ccnt);
				avail = ccnt + 8;
				while (avail >= 3 && emitted < elem_count) begin
					w[n].bits       = weight_float_bits(acc[2:0], scl[emitted[7:6]]);
					w[n].idx        = emitted;
					w[n].run_end    = 1'b0;
					w[n].tensor_end = (emitted + 1 == elem_count);
					acc     = acc >> 3;
					avail  -= 3;
					emitted = emitted + 1;
					n++;
				end
				cbits = acc[1:0];
				ccnt  = (avail < 3) ? 2'(avail) : 2'd0;
			end
			blk_pos = (blk_pos == p3gsd_pkg::BLOCK_BYTES - 1) ? 7'd0 : blk_pos + 7'd1;
			if (n > 0)
				w[n - 1].run_end = 1'b1;
			for (int k = 0; k < n; k++)
				fresh.push_back(w[k]);
		end
	endtask

	always @(posedge clk) begin
		weight_t got;
		weight_t want;
		plan_t   p;
		bit      active;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d weights outstanding", cycle_count,
				pending_weights.size());
			$display("CHECK FAILED");
			$finish;
		end
		if (pop && !empty) begin
			got = {weight_bits, weight_index, last_of_run, last_of_tensor};
			if (pending_weights.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected weight: bits %h index %0d run %b tensor %b",
						got.bits, got.idx, got.run_end, got.tensor_end);
			end else begin
				want = pending_weights.pop_front();
				weights_checked++;
				if (got.bits !== want.bits || got.idx !== want.idx ||
					got.run_end !== want.run_end || got.tensor_end !== want.tensor_end) begin
					errors++;
					if (errors <= 10)
						$display({"weight mismatch: expected bits %h index %0d run %b tensor %b,",
							" got bits %h index %0d run %b tensor %b"},
							want.bits, want.idx, want.run_end, want.tensor_end,
							got.bits, got.idx, got.run_end, got.tensor_end);
				end
			end
		end
		if (push && !full) begin
			p = plan_q.pop_front();
			items_accepted++;
			if (tensor_start)
				tensor_starts++;
			dequant_byte(data_byte, tensor_start, active);
			if (active)
				useful_items++;
			if (p.typed) begin
				for (int k = 0; k < p.nres; k++) begin
					want.bits       = p.w[k];
					want.idx        = p.idx0 + k;
					want.run_end    = (k == p.nres - 1);
					want.tensor_end = p.lot && (k == p.nres - 1);
					pending_weights.push_back(want);
				end
			end else begin
				foreach (fresh[k])
					pending_weights.push_back(fresh[k]);
			end
		end
		if (cfg_we)
			elem_count = cfg_wdata;
	end

	function automatic int idle_cycles(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 9))
			0, 1:    return $urandom_range(1, 8);
			2, 3, 4: return $urandom_range(9, 200);
			5, 6:    return $urandom_range(201, 1100);
			7:       return 32'd0;
			8:       return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 3);
		endcase
	endfunction

	function automatic row_t byte_row(input logic [7:0] d, input logic ts);
		row_t r;
		r      = '0;
		r.kind = ROW_BYTE;
		r.val  = {24'b0, d};
		r.ts   = ts;
		return r;
	endfunction

	function automatic row_t fixed_row(input logic [7:0] d, input logic ts,
		input logic [1:0] n, input logic [31:0] w0, input logic [31:0] w1,
		input logic [31:0] w2, input logic [31:0] idx0, input logic lot);
		row_t r;
		r            = byte_row(d, ts);
		r.plan.typed = 1'b1;
		r.plan.nres  = n;
		r.plan.w[0]  = w0;
		r.plan.w[1]  = w1;
		r.plan.w[2]  = w2;
		r.plan.idx0  = idx0;
		r.plan.lot   = lot;
		return r;
	endfunction

	function automatic row_t count_row(input logic [31:0] v);
		row_t r;
		r      = '0;
		r.kind = ROW_COUNT;
		r.val  = v;
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] d, input logic ts, input plan_t p);
		int g;
		g = idle_cycles(calm);
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		plan_q.push_back(p);
		push         <= 1'b1;
		data_byte    <= d;
		tensor_start <= ts;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic wait_drained();
		// let the checker take in the last accepted byte first
		@(posedge clk);
		while (pending_weights.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_count(input logic [31:0] v);
		push <= 1'b0;
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		counts_written++;
	endtask

	initial begin
		int g;
		int n;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 8);
			pop <= 1'b1;
			repeat (n) @(posedge clk);
			g = idle_cycles(1'b0);
			if (g > 0) begin
				pop <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	initial begin
		bit          first;
		bit          restart;
		logic        ts;
		int          len;
		int          tail;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		push         = 1'b0;
		data_byte    = '0;
		tensor_start = 1'b0;

		// count is zero after reset, then scale-zero signs, max magnitude,
		// count reached inside a byte, raised and lowered mid-tensor, restart mid-block
		script.push_back(fixed_row(8'hA5, 1'b1, 2'd0, '0, '0, '0, '0, 1'b0));
		script.push_back(count_row(32'd300));
		script.push_back(fixed_row(8'h10, 1'b1, 2'd0, '0, '0, '0, '0, 1'b0));
		script.push_back(fixed_row(8'hF8, 1'b0, 2'd0, '0, '0, '0, '0, 1'b0));
		script.push_back(fixed_row(8'h00, 1'b0, 2'd2, 32'h8000_0000, 32'h8000_0000, '0,
			32'd0, 1'b0));
		script.push_back(fixed_row(8'hFF, 1'b0, 2'd3, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0000, 32'd2, 1'b0));
		script.push_back(byte_row(8'h92, 1'b0));
		script.push_back(byte_row(8'h49, 1'b0));
		script.push_back(byte_row(8'h24, 1'b0));
		script.push_back(byte_row(8'hB6, 1'b0));
		script.push_back(byte_row(8'h6D, 1'b0));
		script.push_back(byte_row(8'hDB, 1'b0));
		script.push_back(count_row(32'd1));
		script.push_back(fixed_row(8'hFF, 1'b1, 2'd0, '0, '0, '0, '0, 1'b0));
		script.push_back(fixed_row(8'hFF, 1'b0, 2'd0, '0, '0, '0, '0, 1'b0));
		script.push_back(fixed_row(8'hFF, 1'b0, 2'd1, 32'h4052_0000, '0, '0, 32'd0, 1'b1));
		script.push_back(fixed_row(8'h00, 1'b0, 2'd0, '0, '0, '0, '0, 1'b0));
		script.push_back(count_row(32'hFFFF_FFFF));
		script.push_back(byte_row(8'h00, 1'b0));
		script.push_back(byte_row(8'hFF, 1'b0));
		script.push_back(count_row(32'd2));
		script.push_back(fixed_row(8'h55, 1'b0, 2'd0, '0, '0, '0, '0, 1'b0));
		script.push_back(count_row(32'd500));
		script.push_back(byte_row(8'h00, 1'b1));
		script.push_back(byte_row(8'h3C, 1'b0));
		script.push_back(byte_row(8'hC3, 1'b0));
		script.push_back(byte_row(8'h5A, 1'b1));
		script.push_back(byte_row(8'h81, 1'b0));
		script.push_back(byte_row(8'h7E, 1'b0));
		script.push_back(byte_row(8'h92, 1'b0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_COUNT)
				set_count(script[i].val);
			else
				send_byte(script[i].val[7:0], script[i].ts, script[i].plan);
		end

		// random tensors: mostly well-formed streams, some stray restarts
		first = 1'b1;
		while (useful_items < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			if (first || $urandom_range(0, 5) != 0)
				set_count(pick_count());
			restart = first || ($urandom_range(0, 4) != 0);
			first   = 1'b0;
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 260) : $urandom_range(3, 60);
			for (int i = 0; i < len && useful_items < ITEM_TARGET; i++) begin
				ts = (i == 0 && restart) || ($urandom_range(0, 80) == 0);
				send_byte(pick_byte(), ts, loose);
				if (emitted >= elem_count) begin
					tail = $urandom_range(0, 3);
					repeat (tail) send_byte(pick_byte(), 1'b0, loose);
					break;
				end
			end
		end

		push <= 1'b0;
		calm = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		errors += pending_weights.size();

		$display("%0d bytes accepted (%0d live), %0d tensor starts, %0d count settings",
			items_accepted, useful_items, tensor_starts, counts_written);
		$display("%0d weights checked, %0d errors", weights_checked, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
sv/p3gsd_pkg.sv
sv/p3gsd_front.sv
sv/p3gsd_queue.sv
sv/p3gsd_back.sv
sv/packed_3bit_group_scale_dequant_core.sv
tb/packed_3bit_group_scale_dequant_core_tb.sv
